### sv/rrfl_pkg.sv
// Shared constants and helpers for the register rename free list.
package rrfl_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned ArchRegsDef = 64;
  localparam int unsigned PhysRegsDef = 128;

  // Fixed field widths on the request and response channels.
  localparam int unsigned ArchFieldW = 6;
  localparam int unsigned OutW       = 7;

  // Map table read ports, one per renamed operand.
  localparam int unsigned MapRdPorts = 3;
  localparam int unsigned RdSrc1     = 0;
  localparam int unsigned RdSrc2     = 1;
  localparam int unsigned RdDest     = 2;

  // Width that holds any physical number or reset map value.
  function automatic int unsigned val_width(int unsigned arch_regs, int unsigned phys_regs);
    int unsigned aw;
    int unsigned pw;
    aw = $clog2(arch_regs);
    pw = $clog2(phys_regs);
    return (pw > aw) ? pw : aw;
  endfunction

endpackage

### sv/rrfl_if.sv
// Request and response channel interfaces of the register rename free list.
interface rrfl_req_if import rrfl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  src1_present;
  logic [ArchFieldW-1:0] src1_arch;
  logic                  src2_present;
  logic [ArchFieldW-1:0] src2_arch;
  logic                  dest_present;
  logic [ArchFieldW-1:0] dest_arch;

  modport source (
    output valid, src1_present, src1_arch, src2_present, src2_arch, dest_present, dest_arch,
    input  ready
  );
  modport sink (
    input  valid, src1_present, src1_arch, src2_present, src2_arch, dest_present, dest_arch,
    output ready
  );
endinterface

interface rrfl_rsp_if import rrfl_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] src1_phys;
  logic [OutW-1:0] src2_phys;
  logic [OutW-1:0] dest_phys;
  logic [OutW-1:0] freed_phys;
  logic            rename_error;

  modport source (
    output valid, src1_phys, src2_phys, dest_phys, freed_phys, rename_error,
    input  ready
  );
  modport sink (
    input  valid, src1_phys, src2_phys, dest_phys, freed_phys, rename_error,
    output ready
  );
endinterface

### sv/rrfl_map_table.sv
// Architectural-to-physical map table: three replicated banks, registered reads, bypass.
module rrfl_map_table import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS = ArchRegsDef,
  parameter int unsigned PHYS_REGS = PhysRegsDef
) (
  input  logic                                                          clk_i,
  input  logic                                                          rst_ni,
  input  logic                                                          rd_en_i,
  input  logic [MapRdPorts-1:0][$clog2(ARCH_REGS)-1:0]                  rd_idx_i,
  input  logic                                                          wr_en_i,
  input  logic [$clog2(ARCH_REGS)-1:0]                                  wr_idx_i,
  input  logic [val_width(ARCH_REGS, PHYS_REGS)-1:0]                    wr_data_i,
  output logic [MapRdPorts-1:0][val_width(ARCH_REGS, PHYS_REGS)-1:0]    rd_data_o
);

  localparam int unsigned IdxW = $clog2(ARCH_REGS);
  localparam int unsigned ValW = val_width(ARCH_REGS, PHYS_REGS);

  logic [ValW-1:0]      bank_q [MapRdPorts][ARCH_REGS];
  logic [ARCH_REGS-1:0] vld_q;
  logic [ValW-1:0]      rd_q   [MapRdPorts];
  logic [IdxW-1:0]      ridx_q [MapRdPorts];
  logic [MapRdPorts-1:0] rdv_q;
  logic [MapRdPorts-1:0] byp_q;
  logic [ValW-1:0]      byp_dat_q;

  // Mark entries once written; an unwritten entry reads as its own index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int b = 0; b < MapRdPorts; b++) begin
        bank_q[b][wr_idx_i] <= wr_data_i;
      end
    end
    if (rd_en_i) begin
      for (int p = 0; p < MapRdPorts; p++) begin
        rd_q[p]   <= bank_q[p][rd_idx_i[p]];
        ridx_q[p] <= rd_idx_i[p];
        rdv_q[p]  <= vld_q[rd_idx_i[p]];
        // take the same-cycle write in place of the stale array word
        byp_q[p]  <= wr_en_i && (wr_idx_i == rd_idx_i[p]);
      end
      byp_dat_q <= wr_data_i;
    end
  end

  always_comb begin
    for (int p = 0; p < MapRdPorts; p++) begin
      if (byp_q[p]) begin
        rd_data_o[p] = byp_dat_q;
      end else if (rdv_q[p]) begin
        rd_data_o[p] = rd_q[p];
      end else begin
        rd_data_o[p] = ValW'(ridx_q[p]);
      end
    end
  end

endmodule

### sv/rrfl_free_fifo.sv
// Free-list ring: pop at the head, push the freed register into the slot just popped.
module rrfl_free_fifo import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS = ArchRegsDef,
  parameter int unsigned PHYS_REGS = PhysRegsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       pop_i,
  input  logic                                       wr_en_i,
  input  logic [val_width(ARCH_REGS, PHYS_REGS)-1:0] wr_data_i,
  output logic [val_width(ARCH_REGS, PHYS_REGS)-1:0] rd_data_o
);

  localparam int unsigned ValW  = val_width(ARCH_REGS, PHYS_REGS);
  localparam int unsigned Depth = (PHYS_REGS > ARCH_REGS) ? (PHYS_REGS - ARCH_REGS) : 1;
  localparam int unsigned SlotW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [ValW-1:0]  mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [SlotW-1:0] head_q;
  logic [SlotW-1:0] head_d;
  logic [SlotW-1:0] slot_q;
  logic [ValW-1:0]  rd_q;
  logic             rdv_q;
  logic             byp_q;
  logic [ValW-1:0]  byp_dat_q;

  // Pops and pushes always pair up, so head and tail coincide: one pointer.
  assign head_d = (head_q == SlotW'(Depth - 1)) ? '0 : head_q + SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      vld_q  <= '0;
    end else begin
      if (pop_i) begin
        head_q <= head_d;
      end
      if (wr_en_i) begin
        vld_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_q] <= wr_data_i;
    end
    if (pop_i) begin
      rd_q      <= mem_q[head_q];
      rdv_q     <= vld_q[head_q];
      byp_q     <= wr_en_i && (slot_q == head_q);
      byp_dat_q <= wr_data_i;
      slot_q    <= head_q;
    end
  end

  // Unwritten slots hold the upper physical registers in ascending order.
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_dat_q;
    end else if (rdv_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = ValW'(ARCH_REGS) + ValW'(slot_q);
    end
  end

endmodule

### sv/register_rename_free_list.sv
// Top level of the register rename stage: map table, free list and response register.
//
// One rename request enters on req_i per cycle (valid/ready). It carries up to two
// source and one destination architectural register. The response on rsp_o returns
// the mapped sources, the newly allocated destination and the register it frees.
// From acceptance to rsp_o.valid, the map banks and the free list first register their
// reads, then the result lands in the response register. The sustained rate is one
// request per cycle while rsp_o.ready stays high, set by one read per map bank and one
// read-and-write of the free-list slot per request; back-to-back hazards are bypassed.
// When rsp_o.ready is low the response holds and one more request may sit in the
// read stage; req_i.ready drops only when both are full.
// Reset returns the map to identity and the free list to the upper physical
// registers through per-entry valid bits, so requests are taken from the first
// cycle after reset with no clearing pass. rename_error flags a destination request
// when the free list is empty (only with PHYS_REGS not above ARCH_REGS); nothing
// changes then.
module register_rename_free_list import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS = ArchRegsDef,
  parameter int unsigned PHYS_REGS = PhysRegsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrfl_req_if.sink   req_i,
  rrfl_rsp_if.source rsp_o
);

  localparam int unsigned IdxW      = $clog2(ARCH_REGS);
  localparam int unsigned ValW      = val_width(ARCH_REGS, PHYS_REGS);
  localparam int unsigned ArchVals  = 2 ** ArchFieldW;
  localparam bit          HasFree   = PHYS_REGS > ARCH_REGS;

  // Fold every encodable architectural field onto the implemented registers.
  function automatic logic [ArchVals*IdxW-1:0] build_mod_tab();
    logic [ArchVals*IdxW-1:0] tab;
    tab = '0;
    for (int i = 0; i < ArchVals; i++) begin
      tab[i*IdxW +: IdxW] = IdxW'(i % ARCH_REGS);
    end
    return tab;
  endfunction

  localparam logic [ArchVals*IdxW-1:0] ModTab = build_mod_tab();

  // Request handshake and read-stage control
  logic req_fire;
  logic alloc_in;
  logic s_fire;
  logic s_vld_q;
  logic s_src1_q;
  logic s_src2_q;
  logic s_dest_q;
  logic s_alloc_q;
  logic [IdxW-1:0] s_dest_idx_q;

  logic [MapRdPorts-1:0][IdxW-1:0] rd_idx;
  logic [MapRdPorts-1:0][ValW-1:0] map_rd;
  logic [ValW-1:0]                 free_rd;

  // Response register
  logic            out_vld_q;
  logic [OutW-1:0] out_src1_q;
  logic [OutW-1:0] out_src2_q;
  logic [OutW-1:0] out_dest_q;
  logic [OutW-1:0] out_freed_q;
  logic            out_err_q;

  // Advance the read stage whenever the response register is free or draining.
  assign s_fire      = s_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !s_vld_q || s_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  // Allocation never fails while the free list has any depth: pops and pushes pair.
  assign alloc_in = req_i.dest_present && HasFree;

  assign rd_idx[RdSrc1] = ModTab[req_i.src1_arch*IdxW +: IdxW];
  assign rd_idx[RdSrc2] = ModTab[req_i.src2_arch*IdxW +: IdxW];
  assign rd_idx[RdDest] = ModTab[req_i.dest_arch*IdxW +: IdxW];

  rrfl_map_table #(
    .ARCH_REGS (ARCH_REGS),
    .PHYS_REGS (PHYS_REGS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (req_fire),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (s_fire && s_alloc_q),
    .wr_idx_i  (s_dest_idx_q),
    .wr_data_i (free_rd),
    .rd_data_o (map_rd)
  );

  // The old mapping of the destination goes straight back into the slot just popped.
  rrfl_free_fifo #(
    .ARCH_REGS (ARCH_REGS),
    .PHYS_REGS (PHYS_REGS)
  ) u_free (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pop_i     (req_fire && alloc_in),
    .wr_en_i   (s_fire && s_alloc_q),
    .wr_data_i (map_rd[RdDest]),
    .rd_data_o (free_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_fire) begin
        s_vld_q <= 1'b1;
      end else if (s_fire) begin
        s_vld_q <= 1'b0;
      end
      if (s_fire) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold request flags alongside the registered reads.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s_src1_q     <= req_i.src1_present;
      s_src2_q     <= req_i.src2_present;
      s_dest_q     <= req_i.dest_present;
      s_alloc_q    <= alloc_in;
      s_dest_idx_q <= rd_idx[RdDest];
    end
  end

  // Drop absent operands to zero and mask physical numbers to the field width.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_src1_q  <= s_src1_q  ? OutW'(map_rd[RdSrc1]) : '0;
      out_src2_q  <= s_src2_q  ? OutW'(map_rd[RdSrc2]) : '0;
      out_dest_q  <= s_alloc_q ? OutW'(free_rd)        : '0;
      out_freed_q <= s_alloc_q ? OutW'(map_rd[RdDest]) : '0;
      out_err_q   <= s_dest_q && !HasFree;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.src1_phys    = out_src1_q;
  assign rsp_o.src2_phys    = out_src2_q;
  assign rsp_o.dest_phys    = out_dest_q;
  assign rsp_o.freed_phys   = out_freed_q;
  assign rsp_o.rename_error = out_err_q;

endmodule

### sv/rrfl_checker.sv
// Port-level checks for the register rename free list, bound to the top level.
module rrfl_checker import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS = ArchRegsDef,
  parameter int unsigned PHYS_REGS = PhysRegsDef
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [OutW-1:0] src1_phys_i,
  input logic [OutW-1:0] src2_phys_i,
  input logic [OutW-1:0] dest_phys_i,
  input logic [OutW-1:0] freed_phys_i,
  input logic            rename_error_i
);

  logic [1:0] cnt_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // Count requests accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= 2'(cnt_q + 2'(req_fire) - 2'(rsp_fire));
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(src1_phys_i)
      && $stable(src2_phys_i) && $stable(dest_phys_i) && $stable(freed_phys_i)
      && $stable(rename_error_i))
    else $error("response changed while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> cnt_q != 2'd0)
    else $error("response without an outstanding request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more than two requests in flight");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rename_error_i |-> dest_phys_i == '0 && freed_phys_i == '0
      && PHYS_REGS <= ARCH_REGS)
    else $error("rename error with an allocation or a non-empty free list");

  // Map and free list partition the physical registers, so the two never meet.
  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && PHYS_REGS <= 128 && dest_phys_i != '0 |-> dest_phys_i != freed_phys_i)
    else $error("allocated register equals freed register");

endmodule

bind register_rename_free_list rrfl_checker #(
  .ARCH_REGS (ARCH_REGS),
  .PHYS_REGS (PHYS_REGS)
) u_rrfl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .src1_phys_i    (rsp_o.src1_phys),
  .src2_phys_i    (rsp_o.src2_phys),
  .dest_phys_i    (rsp_o.dest_phys),
  .freed_phys_i   (rsp_o.freed_phys),
  .rename_error_i (rsp_o.rename_error)
);
